@@ hw/rtl/fdp_pkg.sv @@
// fdp_pkg: types and constants for the framed decimal field parser
// no dependencies; imported by fdp_core and framed_decimal_field_parser_unit

package fdp_pkg;

    localparam logic [7:0] COMMA_BYTE   = 8'h2C;
    localparam logic [7:0] ZERO_BYTE    = 8'h30;
    localparam logic [7:0] START_RESET  = 8'd60;
    localparam logic [7:0] STOP_RESET   = 8'd62;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_MARKER  = 1'b1;

    localparam logic [1:0] FIELD_ONE   = 2'd0;
    localparam logic [1:0] FIELD_TWO   = 2'd1;
    localparam logic [1:0] FIELD_THREE = 2'd2;
    localparam logic [1:0] FIELD_DONE  = 2'd3;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] stop_marker;
    } fdp_markers_t;

    typedef struct packed {
        logic [15:0] field_three;
        logic [7:0]  field_two;
        logic [7:0]  field_one;
    } fdp_fields_t;

endpackage

@@ hw/rtl/fdp_core.sv @@
// fdp_core: packet state and decimal accumulators, one byte per step
// depends on fdp_pkg; result flag is combinational from current state and rx_byte, fields from current state

module fdp_core
    import fdp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    input  fdp_markers_t markers,
    output logic         emit,
    output fdp_fields_t  fields
);

    logic        in_packet_reg, in_packet_next;
    logic [1:0]  field_index_reg, field_index_next;
    logic [7:0]  acc_one_reg, acc_one_next;
    logic [7:0]  acc_two_reg, acc_two_next;
    logic [15:0] acc_three_reg, acc_three_next;

    logic        is_start, is_stop, is_comma;
    logic [7:0]  digit8;
    logic [15:0] digit16;

    assign is_start = (rx_byte == markers.start_marker);
    assign is_stop  = (rx_byte == markers.stop_marker);
    assign is_comma = (rx_byte == COMMA_BYTE);
    assign digit8   = rx_byte - ZERO_BYTE;
    assign digit16  = {8'd0, rx_byte} - {8'd0, ZERO_BYTE};

    assign emit   = !is_start && in_packet_reg && is_stop;
    assign fields = '{field_three: acc_three_reg, field_two: acc_two_reg,
                      field_one: acc_one_reg};

    always_comb begin
        in_packet_next   = in_packet_reg;
        field_index_next = field_index_reg;
        acc_one_next     = acc_one_reg;
        acc_two_next     = acc_two_reg;
        acc_three_next   = acc_three_reg;
        if (is_start) begin
            in_packet_next   = 1'b1;
            field_index_next = FIELD_ONE;
            acc_one_next     = 8'd0;
            acc_two_next     = 8'd0;
            acc_three_next   = 16'd0;
        end else if (in_packet_reg) begin
            if (is_stop) begin
                in_packet_next = 1'b0;
            end else if (is_comma) begin
                if (field_index_reg != FIELD_DONE) begin
                    field_index_next = field_index_reg + 2'd1;
                end
            end else begin
                // times ten as two shifts and an add
                case (field_index_reg)
                    FIELD_ONE: begin
                        acc_one_next = (acc_one_reg << 3) + (acc_one_reg << 1) + digit8;
                    end
                    FIELD_TWO: begin
                        acc_two_next = (acc_two_reg << 3) + (acc_two_reg << 1) + digit8;
                    end
                    FIELD_THREE: begin
                        acc_three_next = (acc_three_reg << 3) + (acc_three_reg << 1)
                                         + digit16;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg   <= 1'b0;
            field_index_reg <= FIELD_ONE;
            acc_one_reg     <= 8'd0;
            acc_two_reg     <= 8'd0;
            acc_three_reg   <= 16'd0;
        end else if (step) begin
            in_packet_reg   <= in_packet_next;
            field_index_reg <= field_index_next;
            acc_one_reg     <= acc_one_next;
            acc_two_reg     <= acc_two_next;
            acc_three_reg   <= acc_three_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && emit) |=> !in_packet_reg)
        else $error("packet still open after a result");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && is_start) |=> (in_packet_reg && field_index_reg == FIELD_ONE
                                && acc_one_reg == 8'd0 && acc_two_reg == 8'd0
                                && acc_three_reg == 16'd0))
        else $error("start marker did not clear the packet state");

    a_index_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && field_index_reg == FIELD_DONE && !is_start) |=>
            (field_index_reg == FIELD_DONE))
        else $error("field index left saturation without a start marker");
`endif

endmodule

@@ hw/rtl/framed_decimal_field_parser_unit.sv @@
// Framed decimal field parser: usage
// s_axis (tdata = rx_byte[7:0]) carries raw received bytes, one per transfer.
// A start marker opens or restarts a packet, commas separate up to three
// decimal fields, a stop marker inside a packet yields one transfer on m_axis
// with tdata = field_one[7:0], field_two[15:8], field_three[31:16].
// Bytes outside a packet are dropped; digits after a third comma are ignored.
// Config channel: cfg_index 0 = start marker (reset 60), 1 = stop marker
// (reset 62); cfg_ready is always high, write only while the block is idle.
// Path: a byte is held in the input register, then processed in fdp_core;
// a result is held in the output register and shown on m_axis.
// Throughput: one byte per cycle while no result is blocked, set by the
// accumulator update in fdp_core between the input and output registers.
// When m_tready is low and a result waits, bytes that produce no result still
// move on; a byte that would produce a result waits in the input register and
// s_tready falls until the output register is free.
// Reset (aresetn low, synchronous) empties both registers, closes any packet
// and restores the default markers.
// depends on fdp_pkg and fdp_core

module framed_decimal_field_parser_unit
    import fdp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // rx_byte[7:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // field_one[7:0], field_two[15:8], field_three[31:16]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    fdp_fields_t  out_fields_reg;
    fdp_markers_t markers_reg;

    logic         emit;
    fdp_fields_t  fields;
    logic         out_free;
    logic         step;

    assign out_free  = !out_valid_reg || m_tready;
    // a byte with no result never needs the output register
    assign step      = in_valid_reg && (out_free || !emit);
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_fields_reg;

    fdp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .markers (markers_reg),
        .emit    (emit),
        .fields  (fields)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (step && emit) begin
            out_fields_reg <= fields;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            markers_reg.start_marker <= START_RESET;
            markers_reg.stop_marker  <= STOP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_MARKER: markers_reg.start_marker <= cfg_data;
                REG_STOP_MARKER:  markers_reg.stop_marker  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_stall_only_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready && emit))
        else $error("input stalled without a blocked result");

    a_result_from_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without a byte in the input register");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_fields_reg)))
        else $error("waiting result lost or overwritten");
`endif

endmodule
